FILE: sv/tspf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tspf_pkg
// Constants, types and the PID match function of the transport stream
// sync and PID filter.
// ----------------------------------------------------------------------------
package tspf_pkg;

    localparam int PACKET_BYTES  = 188;
    localparam int PID_ENTRIES   = 7;
    localparam int TARGET_CHAINS = 8;
    localparam int ENTRY_REGS    = 7;

    localparam int CNT_W   = $clog2(PACKET_BYTES + 1);
    localparam int ENTRY_W = 22;
    localparam int PID_W   = 13;
    localparam int MASK_W  = 8;
    localparam int IDX_W   = 3;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PACKET_BYTES);
    localparam logic [CNT_W-1:0] LAST_PHASE = CNT_W'(PACKET_BYTES - 1);

    localparam logic [7:0]        SYNC_BYTE  = 8'h47;
    localparam logic [7:0]        PID_HI_BITS = 8'h1F;
    localparam logic [7:0]        TEI_BIT    = 8'h80;
    localparam logic [7:0]        SCRAM_BITS = 8'hC0;
    localparam logic [MASK_W-1:0] CHAIN_MASK = MASK_W'((1 << TARGET_CHAINS) - 1);

    localparam logic [IDX_W-1:0] REG_INPUT_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PID_ENTRY_0 = 3'd1;

    localparam int ENABLE_BIT = 21;
    localparam int PID_LSB    = 8;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef entry_t entry_arr_t [ENTRY_REGS];

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              tei;
        logic              scram;
    } hdr_t;

    function automatic logic [MASK_W-1:0] union_mask(
        input entry_arr_t       entries,
        input logic             any_pid,
        input logic [PID_W-1:0] pid
    );
        logic [MASK_W-1:0] m;
        m = '0;
        for (int k = 0; k < PID_ENTRIES; k++) begin
            if (entries[k][ENABLE_BIT] &&
                (any_pid || entries[k][PID_LSB +: PID_W] == pid))
            begin
                m = m | entries[k][MASK_W-1:0];
            end
        end
        return m & CHAIN_MASK;
    endfunction

endpackage
`default_nettype wire

FILE: sv/ts_sync_pid_filter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ts_sync_pid_filter_core
// Byte-serial transport stream sync hunter and PID filter with raw bypass.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  in        sink       in_valid/in_stall   stream_byte
//  out       source     out_valid/out_stall out_byte, target_mask, packet_first,
//                                           packet_last, transport_error, scrambled
//  cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
//  One word per cycle sustained while out_stall is low; in raw mode a word passes
//  from the input register straight to the output register, and in stream mode
//  the output register takes the word leaving the 188-byte shift line instead.
//  Reset clears control state; the shift line is refilled before it is read.
//  out_stall holds the output register; in_stall rises only when both the
//  input and output registers are full and the output is stalled.
// ----------------------------------------------------------------------------
module ts_sync_pid_filter_core
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      in_valid,
    output      logic                      in_stall,
    input  wire logic [7:0]                stream_byte,

    output      logic                      out_valid,
    input  wire logic                      out_stall,
    output      logic [7:0]                out_byte,
    output      logic [7:0]                target_mask,
    output      logic                      packet_first,
    output      logic                      packet_last,
    output      logic                      transport_error,
    output      logic                      scrambled,

    input  wire logic                      cfg_valid,
    output      logic                      cfg_ready,
    input  wire logic [tspf_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [tspf_pkg::ENTRY_W-1:0] cfg_data
);

    logic                       mode_reg;
    tspf_pkg::entry_arr_t       entry_reg;

    logic                       in_valid_reg;
    logic [7:0]                 byte_reg;

    logic [7:0]                 line_reg [tspf_pkg::PACKET_BYTES];
    logic [tspf_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic [tspf_pkg::CNT_W-1:0] phase_reg, phase_next;
    logic                       locked_reg, locked_next;
    tspf_pkg::hdr_t             hdr_reg, hdr_next;

    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_byte_reg, out_byte_next;
    logic [7:0]                 mask_out_reg, mask_out_next;
    logic                       first_reg, first_next;
    logic                       last_reg, last_next;
    logic                       tei_reg, tei_next;
    logic                       scram_reg, scram_next;

    logic                       advance;
    logic                       shift_en;
    logic                       lock_eff;
    logic [tspf_pkg::CNT_W-1:0] phase_cur;
    logic [7:0]                 oldest;
    logic [tspf_pkg::PID_W-1:0] pid;
    tspf_pkg::hdr_t             hdr_eff;
    logic [7:0]                 raw_mask;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            for (int k = 0; k < tspf_pkg::ENTRY_REGS; k++)
            begin
                entry_reg[k] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == tspf_pkg::REG_INPUT_MODE)
            begin
                mode_reg <= cfg_data[0];
            end
            else
            begin
                entry_reg[cfg_index - tspf_pkg::REG_PID_ENTRY_0] <= cfg_data;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= stream_byte;
        end
    end

    // shift line: index 0 newest, last index oldest
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            line_reg[0] <= byte_reg;
            for (int i = 1; i < tspf_pkg::PACKET_BYTES; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign oldest   = line_reg[tspf_pkg::PACKET_BYTES-1];
    assign pid      = {line_reg[tspf_pkg::PACKET_BYTES-2][4:0] & tspf_pkg::PID_HI_BITS[4:0],
                       line_reg[tspf_pkg::PACKET_BYTES-3]};
    assign raw_mask = tspf_pkg::union_mask(entry_reg, 1'b1, '0);

    always_comb
    begin
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        locked_next    = locked_reg;
        hdr_next       = hdr_reg;
        shift_en       = 1'b0;
        lock_eff       = locked_reg;
        phase_cur      = locked_reg ? phase_reg : '0;
        hdr_eff        = hdr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        mask_out_next  = mask_out_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        tei_next       = tei_reg;
        scram_next     = scram_reg;

        if (advance)
        begin
            out_valid_next = 1'b0;
            if (!mode_reg)
            begin
                fill_next      = '0;
                locked_next    = 1'b0;
                phase_next     = '0;
                out_valid_next = (raw_mask != '0);
                out_byte_next  = byte_reg;
                mask_out_next  = raw_mask;
                first_next     = 1'b0;
                last_next      = 1'b0;
                tei_next       = 1'b0;
                scram_next     = 1'b0;
            end
            else if (fill_reg < tspf_pkg::FULL_COUNT)
            begin
                shift_en  = 1'b1;
                fill_next = fill_reg + tspf_pkg::CNT_W'(1);
            end
            else
            begin
                shift_en = 1'b1;
                if (!locked_reg)
                begin
                    lock_eff = (oldest == tspf_pkg::SYNC_BYTE) &&
                               (byte_reg == tspf_pkg::SYNC_BYTE);
                end
                else if (phase_reg == '0 && oldest != tspf_pkg::SYNC_BYTE)
                begin
                    lock_eff = 1'b0;
                end
                locked_next = lock_eff;

                if (lock_eff)
                begin
                    if (phase_cur == '0)
                    begin
                        hdr_eff.mask  = tspf_pkg::union_mask(entry_reg, 1'b0, pid);
                        hdr_eff.tei   = |(line_reg[tspf_pkg::PACKET_BYTES-2] &
                                          tspf_pkg::TEI_BIT);
                        hdr_eff.scram = |(line_reg[tspf_pkg::PACKET_BYTES-4] &
                                          tspf_pkg::SCRAM_BITS);
                    end
                    hdr_next       = hdr_eff;
                    out_valid_next = (hdr_eff.mask != '0);
                    out_byte_next  = oldest;
                    mask_out_next  = hdr_eff.mask;
                    first_next     = (phase_cur == '0);
                    last_next      = (phase_cur == tspf_pkg::LAST_PHASE);
                    tei_next       = hdr_eff.tei;
                    scram_next     = hdr_eff.scram;
                    phase_next     = (phase_cur == tspf_pkg::LAST_PHASE) ? '0 :
                                     phase_cur + tspf_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            phase_reg     <= '0;
            locked_reg    <= 1'b0;
            hdr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            locked_reg    <= locked_next;
            hdr_reg       <= hdr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        mask_out_reg <= mask_out_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        tei_reg      <= tei_next;
        scram_reg    <= scram_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign target_mask     = mask_out_reg;
    assign packet_first    = first_reg;
    assign packet_last     = last_reg;
    assign transport_error = tei_reg;
    assign scrambled       = scram_reg;

    a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> target_mask != '0)
        else $error("word emitted with empty target mask");

    a_first_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_first |-> out_byte == tspf_pkg::SYNC_BYTE)
        else $error("packet start without sync byte");

    a_lock_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |-> fill_reg == tspf_pkg::FULL_COUNT)
        else $error("locked with partly filled line");

    a_phase_needs_lock: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != '0 |-> locked_reg)
        else $error("packet phase running while hunting");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= tspf_pkg::FULL_COUNT)
        else $error("fill count overrun");

endmodule
`default_nettype wire
